[sv/lpht_pkg.sv]
package lpht_pkg;

    localparam int SLOTS      = 64;
    localparam int KEY_BITS   = 32;
    localparam int ENTRY_BITS = 16;
    localparam int IDX_BITS   = $clog2(SLOTS);
    localparam int CNT_BITS   = 6;
    localparam int PROBE_BITS = IDX_BITS + 1;
    localparam int FOLDS      = (KEY_BITS + IDX_BITS - 1) / IDX_BITS;

    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [ENTRY_BITS-1:0] t_entry;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIPE,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_CHK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        logic   wvalid;
        t_key   wkey;
        t_entry wentry;
        logic   re;
        t_idx   raddr;
    } t_mem_req;

    typedef struct packed {
        logic   valid;
        t_key   key;
        t_entry entry;
    } t_slot;

    // XOR fold of the key into slot-index-wide chunks.
    function automatic t_idx home_of(input t_key k);
        logic [FOLDS*IDX_BITS-1:0] ext;
        t_idx h;
        ext = '0;
        ext[KEY_BITS-1:0] = k;
        h = '0;
        for (int i = 0; i < FOLDS; i++) begin
            h = h ^ ext[i*IDX_BITS +: IDX_BITS];
        end
        return h;
    endfunction

endpackage

[sv/lpht_if.sv]
interface lpht_in_if;
    import lpht_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            op;
    logic [KEY_BITS-1:0]   key;
    logic [ENTRY_BITS-1:0] entry_index;
    modport source (output valid, op, key, entry_index, input ready);
    modport sink (input valid, op, key, entry_index, output ready);
endinterface

interface lpht_out_if;
    import lpht_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [ENTRY_BITS-1:0] found_entry;
    logic [CNT_BITS-1:0]   resident_count;
    modport source (output valid, ok, found_entry, resident_count, input ready);
    modport sink (input valid, ok, found_entry, resident_count, output ready);
endinterface

[sv/lpht_store.sv]
module lpht_store
    import lpht_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_slot    o_rdata
);

    logic [KEY_BITS+ENTRY_BITS:0] r_mem [SLOTS];
    logic [KEY_BITS+ENTRY_BITS:0] r_rd;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= {i_req.wvalid, i_req.wkey, i_req.wentry};
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = t_slot'(r_rd);

endmodule

[sv/lpht_ctrl.sv]
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  t_cnt         i_cfg_wdata,
    lpht_in_if.sink      i_req,
    lpht_out_if.source   o_rsp,
    input  t_slot        i_rdata,
    output t_mem_req     o_mem
);

    t_state r_state, n_state;
    t_op    r_op;
    t_key   r_key;
    t_entry r_entry;
    t_idx   r_ptr, n_ptr;
    t_idx   r_hole, n_hole;
    logic [PROBE_BITS-1:0] r_cnt, n_cnt;
    t_cnt   r_keys, n_keys;
    t_cnt   r_limit;
    logic   r_ok, n_ok;
    t_entry r_fe, n_fe;
    logic   r_ovalid;
    t_idx   h_scan;
    logic   accept;
    logic   wipe_last;

    assign accept = i_req.valid && i_req.ready;
    assign h_scan = home_of(i_rdata.key);
    assign wipe_last = (r_cnt == PROBE_BITS'(SLOTS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cfg_we && i_cfg_wdata == '0) begin
                    n_state = ST_WIPE;
                end else if (accept) begin
                    if (t_op'(i_req.op) == OP_CLEAR) begin
                        n_state = ST_WIPE;
                    end else if (t_op'(i_req.op) == OP_INSERT && r_keys >= r_limit) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_PROBE_RD;
                    end
                end
            end
            ST_WIPE: if (wipe_last) n_state = (r_op == OP_CLEAR) ? ST_DONE : ST_IDLE;
            ST_PROBE_RD: n_state = ST_PROBE_CHK;
            ST_PROBE_CHK: begin
                if (!i_rdata.valid) begin
                    n_state = ST_DONE;
                end else if (i_rdata.key == r_key) begin
                    if (r_op == OP_ERASE && i_rdata.entry == r_entry) begin
                        n_state = ST_SHIFT_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else if (r_cnt == PROBE_BITS'(SLOTS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_PROBE_RD;
                end
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_CHK;
            ST_SHIFT_CHK: begin
                if (!i_rdata.valid || r_cnt == PROBE_BITS'(SLOTS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SHIFT_RD;
                end
            end
            ST_DONE: if (o_rsp.ready || !r_ovalid) n_state = r_ovalid ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory requests.
    always_comb begin
        n_ptr  = r_ptr;
        n_hole = r_hole;
        n_cnt  = r_cnt;
        n_keys = r_keys;
        n_ok   = r_ok;
        n_fe   = r_fe;
        o_mem  = '0;
        o_mem.raddr = r_ptr;
        o_mem.waddr = r_ptr;
        case (r_state)
            ST_IDLE: begin
                n_ok = 1'b0;
                n_fe = '0;
                n_ptr = home_of(i_req.key);
                n_cnt = '0;
                if (i_cfg_we && i_cfg_wdata == '0) begin
                    n_ptr  = '0;
                    n_keys = '0;
                end else if (accept && t_op'(i_req.op) == OP_CLEAR) begin
                    n_ptr  = '0;
                    n_keys = '0;
                    n_ok   = 1'b1;
                end
            end
            ST_WIPE: begin
                o_mem.we = 1'b1;
                n_ptr = r_ptr + 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            ST_PROBE_RD: o_mem.re = 1'b1;
            ST_PROBE_CHK: begin
                if (!i_rdata.valid) begin
                    if (r_op == OP_INSERT) begin
                        o_mem.we     = 1'b1;
                        o_mem.wvalid = 1'b1;
                        o_mem.wkey   = r_key;
                        o_mem.wentry = r_entry;
                        n_keys = r_keys + 1'b1;
                        n_ok   = 1'b1;
                    end
                end else if (i_rdata.key == r_key) begin
                    if (r_op == OP_FIND) begin
                        n_ok = 1'b1;
                        n_fe = i_rdata.entry;
                    end else if (r_op == OP_ERASE && i_rdata.entry == r_entry) begin
                        n_ok   = 1'b1;
                        n_keys = r_keys - 1'b1;
                        n_hole = r_ptr;
                        n_ptr  = r_ptr + 1'b1;
                        n_cnt  = PROBE_BITS'(1);
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SHIFT_RD: o_mem.re = 1'b1;
            ST_SHIFT_CHK: begin
                if (!i_rdata.valid || r_cnt == PROBE_BITS'(SLOTS - 1)) begin
                    // Close the final hole.
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_hole;
                end else begin
                    if (t_idx'(r_hole - h_scan) < t_idx'(r_ptr - h_scan)) begin
                        o_mem.we     = 1'b1;
                        o_mem.waddr  = r_hole;
                        o_mem.wvalid = 1'b1;
                        o_mem.wkey   = i_rdata.key;
                        o_mem.wentry = i_rdata.entry;
                        n_hole = r_ptr;
                    end
                    n_ptr = r_ptr + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_WIPE;
            r_keys   <= '0;
            r_limit  <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_ptr    <= '0;
            r_op     <= OP_FIND;
        end else begin
            r_state <= n_state;
            r_keys  <= n_keys;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (r_state == ST_IDLE && i_cfg_we && i_cfg_wdata == '0) begin
                r_op <= OP_FIND;
            end else if (accept) begin
                r_op <= t_op'(i_req.op);
            end
            if (n_state == ST_DONE && r_state != ST_DONE) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key   <= i_req.key;
            r_entry <= i_req.entry_index;
        end
        r_hole <= n_hole;
        r_ok   <= n_ok;
        r_fe   <= n_fe;
    end

    assign i_req.ready          = (r_state == ST_IDLE) && !i_cfg_we;
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.ok             = r_ok;
    assign o_rsp.found_entry    = r_fe;
    assign o_rsp.resident_count = r_keys;

endmodule

[sv/linear_probe_hash_table_core.sv]
// Each request reads slots one at a time, each probe and each shift step being a read
// followed by a check; an insert refused by the limit goes straight to the result, and
// clear first wipes every slot. Only one item is in flight: the next input is accepted
// only after the result transfer, once the controller is back in idle.
// Reset: synchronous, active low; afterward a clearing pass runs through the slot memory
// while no item is accepted. Limit and count reset to zero.
module linear_probe_hash_table_core
    import lpht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_cnt       i_cfg_wdata,
    lpht_in_if.sink    i_req,
    lpht_out_if.source o_rsp
);

    t_mem_req mem_req;
    t_slot    mem_rdata;

    lpht_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    lpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_rdata     (mem_rdata),
        .o_mem       (mem_req)
    );

endmodule

[bench/tb_linear_probe_hash_table_core.sv]
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_core;
    import lpht_pkg::*;

    typedef struct packed {
        t_op    op;
        t_key   key;
        t_entry entry;
    } t_request;

    typedef struct packed {
        logic   ok;
        t_entry found_entry;
        t_cnt   resident_count;
    } t_response;

    localparam int LIMIT_CYCLES = 3000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cnt i_cfg_wdata;

    lpht_in_if  req_if ();
    lpht_out_if rsp_if ();

    linear_probe_hash_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    // Shadow copy of the table, kept in step with accepted requests.
    logic      shadow_valid [SLOTS];
    t_key      shadow_key   [SLOTS];
    t_entry    shadow_entry [SLOTS];
    int        shadow_count;
    int        shadow_limit;

    t_request  pending_requests [$];
    t_response expected_responses [$];
    int        error_count;
    int        cycle_count;
    int        response_count;
    int        sent_count;
    bit        stimulus_done;
    bit        hold_off_request;
    bit        long_hold_active;

    // Key pool kept small so that finds, duplicates and erases hit often.
    t_key      key_pool [16];

    function automatic t_idx fold_key(input t_key k);
        t_idx h;
        h = '0;
        for (int sh = 0; sh < KEY_BITS; sh += IDX_BITS) begin
            h = h ^ t_idx'(k >> sh);
        end
        return h;
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
        end
        shadow_count = 0;
    endfunction

    function automatic bit search_key(input t_key k, output t_idx where);
        t_idx i;
        i = fold_key(k);
        for (int p = 0; p < SLOTS; p++) begin
            if (!shadow_valid[i]) return 1'b0;
            if (shadow_key[i] == k) begin
                where = i;
                return 1'b1;
            end
            i = i + 1'b1;
        end
        return 1'b0;
    endfunction

    // Backward-shift removal: pull later chain members into the hole.
    function automatic void shift_out(input t_idx slot);
        t_idx hole;
        t_idx scan;
        t_idx h;
        hole = slot;
        scan = slot + 1'b1;
        for (int p = 1; p < SLOTS && shadow_valid[scan]; p++) begin
            h = fold_key(shadow_key[scan]);
            if (t_idx'(hole - h) < t_idx'(scan - h)) begin
                shadow_key[hole]   = shadow_key[scan];
                shadow_entry[hole] = shadow_entry[scan];
                shadow_valid[hole] = 1'b1;
                hole = scan;
            end
            scan = scan + 1'b1;
        end
        shadow_valid[hole] = 1'b0;
    endfunction

    function automatic t_response apply_request(input t_request r);
        t_response rsp;
        t_idx      where;
        t_idx      i;
        rsp = '0;
        case (r.op)
            OP_FIND: begin
                if (search_key(r.key, where)) begin
                    rsp.ok = 1'b1;
                    rsp.found_entry = shadow_entry[where];
                end
            end
            OP_INSERT: begin
                if (shadow_count < shadow_limit) begin
                    i = fold_key(r.key);
                    for (int p = 0; p < SLOTS; p++) begin
                        if (!shadow_valid[i]) begin
                            shadow_valid[i] = 1'b1;
                            shadow_key[i]   = r.key;
                            shadow_entry[i] = r.entry;
                            shadow_count++;
                            rsp.ok = 1'b1;
                            break;
                        end
                        if (shadow_key[i] == r.key) break;
                        i = i + 1'b1;
                    end
                end
            end
            OP_ERASE: begin
                if (search_key(r.key, where) && shadow_entry[where] == r.entry) begin
                    shift_out(where);
                    shadow_count--;
                    rsp.ok = 1'b1;
                end
            end
            default: begin
                empty_table();
                rsp.ok = 1'b1;
            end
        endcase
        rsp.resident_count = t_cnt'(shadow_count);
        return rsp;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) r.op = OP_INSERT;
        else if (pick < 60) r.op = OP_FIND;
        else if (pick < 98) r.op = OP_ERASE;
        else r.op = OP_CLEAR;
        if ($urandom_range(0, 9) < 8) r.key = key_pool[$urandom_range(0, 15)];
        else r.key = $urandom;
        // Erase usually names the right entry so that chains actually shrink.
        if (r.op == OP_ERASE && $urandom_range(0, 3) != 0) r.entry = t_entry'(r.key * 7);
        else if (r.op == OP_INSERT) r.entry = t_entry'(r.key * 7);
        else r.entry = t_entry'($urandom);
        if ($urandom_range(0, 19) == 0) r.entry = t_entry'($urandom);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t timeout with %0d responses outstanding", $time,
                     expected_responses.size());
            $display("FAIL linear_probe_hash_table_core");
            $finish;
        end
    end

    // Driver: offers pending requests with random gaps; predicts on each transfer.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_responses.push_back(apply_request(pending_requests.pop_front()));
                sent_count <= sent_count + 1;
            end
            if (req_if.valid && !req_if.ready) begin
                // Hold the current offer.
            end else if (send_gap > 0) begin
                req_if.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_requests.size() > 0 && !hold_off_request) begin
                req_if.valid <= 1'b1;
                req_if.op          <= pending_requests[0].op;
                req_if.key         <= pending_requests[0].key;
                req_if.entry_index <= pending_requests[0].entry;
                if ($urandom_range(0, 2) == 0) begin
                    send_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(0, 3);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with an occasional long stall of its own.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left <= 0;
        end else if (long_hold_active && stall_left == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= 300;
            long_hold_active <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: compares each response transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_response exp_rsp;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            response_count <= response_count + 1;
            if (expected_responses.size() == 0) begin
                $display("%0t unexpected response ok=%0b found=%0h count=%0d", $time,
                         rsp_if.ok, rsp_if.found_entry, rsp_if.resident_count);
                error_count = error_count + 1;
            end else begin
                exp_rsp = expected_responses.pop_front();
                if (rsp_if.ok !== exp_rsp.ok) begin
                    $display("%0t ok mismatch: expected %0b actual %0b", $time,
                             exp_rsp.ok, rsp_if.ok);
                    error_count = error_count + 1;
                end
                if (rsp_if.found_entry !== exp_rsp.found_entry) begin
                    $display("%0t found_entry mismatch: expected %0h actual %0h", $time,
                             exp_rsp.found_entry, rsp_if.found_entry);
                    error_count = error_count + 1;
                end
                if (rsp_if.resident_count !== exp_rsp.resident_count) begin
                    $display("%0t resident_count mismatch: expected %0d actual %0d", $time,
                             exp_rsp.resident_count, rsp_if.resident_count);
                    error_count = error_count + 1;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || expected_responses.size() > 0 || req_if.valid)
            @(posedge i_clk);
        repeat (2 * SLOTS + 20) @(posedge i_clk);
    endtask

    // Limit writes only while idle; the shadow limit follows at the same edge.
    task automatic write_limit(input int value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t_cnt'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_limit = value;
        if (value == 0) empty_table();
        repeat (2 * SLOTS + 4) @(posedge i_clk);
    endtask

    task automatic queue_request(input t_op op, input t_key k, input t_entry e);
        t_request r;
        r.op = op;
        r.key = k;
        r.entry = e;
        pending_requests.push_back(r);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) pending_requests.push_back(random_request());
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        response_count = 0;
        sent_count = 0;
        stimulus_done = 1'b0;
        hold_off_request = 1'b0;
        long_hold_active = 1'b0;
        shadow_limit = 0;
        empty_table();
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.op = OP_FIND;
        req_if.key = '0;
        req_if.entry_index = '0;
        rsp_if.ready = 1'b0;
        // Pool keys that share home slots, so chains and backward shifts occur.
        for (int i = 0; i < 16; i++) begin
            key_pool[i] = (i < 8) ? t_key'((i * 65) << (6 * (i % 5))) : $urandom;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SLOTS + 8) @(posedge i_clk);

        // Directed: zero limit refuses inserts, then extremes of each field.
        queue_request(OP_INSERT, '0, '0);
        queue_request(OP_FIND, '1, '1);
        wait_drained();
        write_limit(2);
        queue_request(OP_INSERT, '0, '1);
        queue_request(OP_INSERT, 32'h0000_0041, 16'h1234);
        queue_request(OP_INSERT, '1, '0);
        queue_request(OP_INSERT, '0, 16'h5555);
        queue_request(OP_FIND, '0, '0);
        queue_request(OP_ERASE, '0, '0);
        queue_request(OP_ERASE, '0, '1);
        queue_request(OP_FIND, 32'h0000_0041, '0);
        queue_request(OP_CLEAR, '1, '1);
        // Colliding keys: 0, 65 and 4160 all fold to home 0, and 1 lands in the same chain.
        write_limit(32);
        queue_request(OP_INSERT, 32'h0, 16'h1);
        queue_request(OP_INSERT, 32'h41, 16'h2);
        queue_request(OP_INSERT, 32'h1040, 16'h3);
        queue_request(OP_INSERT, 32'h1, 16'h4);
        queue_request(OP_ERASE, 32'h0, 16'h1);
        queue_request(OP_FIND, 32'h1040, 16'h0);
        queue_request(OP_FIND, 32'h41, 16'h0);
        queue_request(OP_FIND, 32'hAAAA_5555, 16'h0);
        wait_drained();
        // Nonzero limit below the count keeps contents but blocks inserts.
        write_limit(1);
        queue_request(OP_INSERT, 32'h77, 16'h7);
        queue_request(OP_FIND, 32'h41, 16'h0);
        write_limit(0);
        queue_request(OP_FIND, 32'h41, 16'h0);

        // Random phases across several limits; a long receiver stall in one.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_limit(32);
                1: write_limit(1);
                2: write_limit(63);
                3: write_limit(8);
                4: write_limit(0);
                default: write_limit(32);
            endcase
            if (phase == 2) long_hold_active = 1'b1;
            queue_random(320);
            if (phase == 3) begin
                // Sender pauses until every response has come back.
                while (pending_requests.size() > 160) @(posedge i_clk);
                hold_off_request = 1'b1;
                while (expected_responses.size() > 0 || req_if.valid) @(posedge i_clk);
                hold_off_request = 1'b0;
            end
        end
        wait_drained();
        stimulus_done = 1'b1;

        $display("Ran %0d requests over limits 0, 1, 2, 8, 32 and 63 with collisions,",
                 sent_count);
        $display("backward-shift erases, clears and stalls; %0d responses checked.",
                 response_count);
        if (error_count == 0 && expected_responses.size() == 0) begin
            $display("PASS linear_probe_hash_table_core");
        end else begin
            $display("FAIL linear_probe_hash_table_core");
        end
        $finish;
    end

endmodule

[files.f]
sv/lpht_pkg.sv
sv/lpht_if.sv
sv/lpht_store.sv
sv/lpht_ctrl.sv
sv/linear_probe_hash_table_core.sv
bench/tb_linear_probe_hash_table_core.sv
